FILE: hdl/swtq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted wake-up timer queue package
// Field widths, operation codes, result status codes and sequencer states.
// ----------------------------------------------------------------------------
package swtq_pkg;

  localparam int TASK_BITS     = 4;
  localparam int NUM_TASKS     = 16;
  localparam int IN_TICK_BITS  = 32;
  localparam int WIDE_TICK_BITS = 64;

  typedef enum logic [1:0] {
    FN_ADD    = 2'd0,
    FN_REMOVE = 2'd1,
    FN_EXPIRE = 2'd2,
    FN_NOP    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_DUP    = 2'd2,
    ST_ABSENT = 2'd3
  } status_t;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_ADD_CMP  = 9'b000000010,
    S_ADD_PUT  = 9'b000000100,
    S_REM_SCAN = 9'b000001000,
    S_EXP_SCAN = 9'b000010000,
    S_EXP_RD   = 9'b000100000,
    S_EXP_OUT  = 9'b001000000,
    S_EXP_MOVE = 9'b010000000,
    S_RESP     = 9'b100000000
  } state_t;

endpackage

FILE: hdl/swtq_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module swtq_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/sorted_wakeup_timer_queue_top.sv
// ----------------------------------------------------------------------------
// Sorted wake-up timer queue
// Task ids kept in wake-tick order in one RAM, walked by a small sequencer.
// ----------------------------------------------------------------------------
// The queue holds up to MAX_ENTRIES task ids in one RAM, sorted by ascending
// wake tick, with ties in arrival order. Every word is handled one at a time
// and cmd_stall stays high until the word is done; for an expiry check that
// includes moving entries up after its last result. An add walks from the
// tail, moving one entry per cycle. A remove walks from the head. An expiry
// check scans the due entries (one per cycle), then reads and outputs each
// woken task in turn, waiting while the result side stalls, and moves each
// remaining entry up, one per cycle. The single RAM port pair and one shared
// tick comparator set this pace. Full-queue and duplicate adds, and removes
// of absent tasks, go straight to the response state.
module sorted_wakeup_timer_queue_top
  import swtq_pkg::*;
#(
  parameter int MAX_ENTRIES = 16,
  parameter int TICK_BITS   = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cmd_valid,
  output logic                    cmd_stall,
  input  logic [1:0]              func,
  input  logic [TASK_BITS-1:0]    task_id,
  input  logic [IN_TICK_BITS-1:0] due_tick,
  input  logic [IN_TICK_BITS-1:0] now_tick,
  output logic                    res_valid,
  input  logic                    res_stall,
  output logic [1:0]              status,
  output logic                    woke,
  output logic [TASK_BITS-1:0]    woken_task,
  output logic                    last
);

  localparam int IW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int EW = TASK_BITS + TICK_BITS;

  state_t                 state, state_next;
  logic [IW-1:0]          idx, idx_next;
  logic [CW-1:0]          count, count_next;
  logic [CW-1:0]          pops, pops_next;
  logic                   found, found_next;
  logic [NUM_TASKS-1:0]   present, present_next;
  status_t                rsp_status, rsp_status_next;

  logic [TASK_BITS-1:0]   op_task;
  logic [TICK_BITS-1:0]   op_wake, op_now;
  logic [WIDE_TICK_BITS-1:0] wake_wide, now_wide;

  logic                   ram_we;
  logic [IW-1:0]          ram_waddr, ram_raddr;
  logic [EW-1:0]          ram_wdata, rd_word, new_word;
  logic [TASK_BITS-1:0]   rd_task;
  logic [TICK_BITS-1:0]   rd_tick, cmp_ref;
  logic                   tick_le;

  logic                   cmd_accept, res_free, load_res;
  logic [1:0]             res_status_d;
  logic                   res_woke_d, res_last_d;
  logic [TASK_BITS-1:0]   res_task_d;

  logic [IW-1:0]          idx_p1, idx_m1;
  logic [CW-1:0]          idx_c, idx_c_p1, count_m1;
  logic                   at_end, exp_last;

  swtq_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(rd_word)
  );

  assign cmd_stall  = (state != S_IDLE);
  assign cmd_accept = cmd_valid && !cmd_stall;
  assign res_free   = !res_valid || !res_stall;

  assign wake_wide = WIDE_TICK_BITS'(due_tick);
  assign now_wide  = WIDE_TICK_BITS'(now_tick);

  assign rd_task  = rd_word[TICK_BITS +: TASK_BITS];
  assign rd_tick  = rd_word[TICK_BITS-1:0];
  assign new_word = {op_task, op_wake};

  // shared comparator: add walks past later ticks, expiry pops due ticks
  assign cmp_ref = (state == S_ADD_CMP) ? op_wake : op_now;
  assign tick_le = (rd_tick <= cmp_ref);

  assign idx_p1   = idx + IW'(1);
  assign idx_m1   = idx - IW'(1);
  assign idx_c    = CW'(idx);
  assign idx_c_p1 = idx_c + CW'(1);
  assign count_m1 = count - CW'(1);
  assign at_end   = (idx_c == count_m1);
  assign exp_last = (idx_c_p1 == pops);

  always_comb begin
    state_next      = state;
    idx_next        = idx;
    count_next      = count;
    pops_next       = pops;
    found_next      = found;
    present_next    = present;
    rsp_status_next = rsp_status;
    ram_we          = 1'b0;
    ram_waddr       = idx;
    ram_wdata       = rd_word;
    ram_raddr       = idx_p1;
    load_res        = 1'b0;
    res_status_d    = ST_OK;
    res_woke_d      = 1'b0;
    res_task_d      = '0;
    res_last_d      = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (cmd_accept) begin
          unique case (func)
            FN_ADD: begin
              if (present[task_id]) begin
                rsp_status_next = ST_DUP;
                state_next      = S_RESP;
              end else if (count == CW'(MAX_ENTRIES)) begin
                rsp_status_next = ST_FULL;
                state_next      = S_RESP;
              end else if (count == '0) begin
                idx_next   = '0;
                state_next = S_ADD_PUT;
              end else begin
                ram_raddr  = count_m1[IW-1:0];
                idx_next   = count_m1[IW-1:0];
                state_next = S_ADD_CMP;
              end
            end
            FN_REMOVE: begin
              if (!present[task_id]) begin
                rsp_status_next = ST_ABSENT;
                state_next      = S_RESP;
              end else begin
                ram_raddr  = '0;
                idx_next   = '0;
                found_next = 1'b0;
                state_next = S_REM_SCAN;
              end
            end
            FN_EXPIRE: begin
              if (count == '0) begin
                rsp_status_next = ST_OK;
                state_next      = S_RESP;
              end else begin
                ram_raddr  = '0;
                idx_next   = '0;
                pops_next  = '0;
                state_next = S_EXP_SCAN;
              end
            end
            FN_NOP: begin
              rsp_status_next = ST_OK;
              state_next      = S_RESP;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_ADD_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = idx_p1;
        if (!tick_le) begin
          ram_wdata = rd_word;
          if (idx == '0) begin
            state_next = S_ADD_PUT;
          end else begin
            ram_raddr = idx_m1;
            idx_next  = idx_m1;
          end
        end else begin
          ram_wdata             = new_word;
          count_next            = count + CW'(1);
          present_next[op_task] = 1'b1;
          rsp_status_next       = ST_OK;
          state_next            = S_RESP;
        end
      end
      S_ADD_PUT: begin
        ram_we                = 1'b1;
        ram_waddr             = idx;
        ram_wdata             = new_word;
        count_next            = count + CW'(1);
        present_next[op_task] = 1'b1;
        rsp_status_next       = ST_OK;
        state_next            = S_RESP;
      end
      S_REM_SCAN: begin
        if (found) begin
          ram_we    = 1'b1;
          ram_waddr = idx_m1;
          ram_wdata = rd_word;
        end
        if (rd_task == op_task) begin
          found_next = 1'b1;
        end
        if (at_end) begin
          count_next            = count_m1;
          present_next[op_task] = 1'b0;
          rsp_status_next       = ST_OK;
          state_next            = S_RESP;
        end else begin
          idx_next = idx_p1;
        end
      end
      S_EXP_SCAN: begin
        if (tick_le) begin
          pops_next = idx_c_p1;
        end
        if (!tick_le || at_end) begin
          if (!tick_le && pops == '0) begin
            rsp_status_next = ST_OK;
            state_next      = S_RESP;
          end else begin
            idx_next   = '0;
            state_next = S_EXP_RD;
          end
        end else begin
          idx_next = idx_p1;
        end
      end
      S_EXP_RD: begin
        ram_raddr = idx;
        if (res_free) begin
          state_next = S_EXP_OUT;
        end
      end
      S_EXP_OUT: begin
        load_res              = 1'b1;
        res_woke_d            = 1'b1;
        res_task_d            = rd_task;
        res_last_d            = exp_last;
        present_next[rd_task] = 1'b0;
        if (exp_last) begin
          if (pops == count) begin
            count_next = '0;
            state_next = S_IDLE;
          end else begin
            idx_next   = pops[IW-1:0];
            ram_raddr  = pops[IW-1:0];
            state_next = S_EXP_MOVE;
          end
        end else begin
          idx_next   = idx_p1;
          state_next = S_EXP_RD;
        end
      end
      S_EXP_MOVE: begin
        ram_we    = 1'b1;
        ram_waddr = IW'(idx_c - pops);
        ram_wdata = rd_word;
        if (at_end) begin
          count_next = count - pops;
          state_next = S_IDLE;
        end else begin
          idx_next = idx_p1;
        end
      end
      S_RESP: begin
        if (res_free) begin
          load_res     = 1'b1;
          res_status_d = rsp_status;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      present <= '0;
      found   <= 1'b0;
      pops    <= '0;
      idx     <= '0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      present <= present_next;
      found   <= found_next;
      pops    <= pops_next;
      idx     <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    rsp_status <= rsp_status_next;
    if (cmd_accept) begin
      op_task <= task_id;
      op_wake <= wake_wide[TICK_BITS-1:0];
      op_now  <= now_wide[TICK_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_res) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      status     <= res_status_d;
      woke       <= res_woke_d;
      woken_task <= res_task_d;
      last       <= res_last_d;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ENTRIES))
    else $error("queue count beyond capacity");

  a_present_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ($countones(present) == int'(count)))
    else $error("present map disagrees with queue count");

  a_out_slot_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXP_OUT) |-> !res_valid)
    else $error("woken task loaded over a pending result");

endmodule
